// ===== sv/sobel_edge_magnitude_macros.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, clocked on clk_i, off during reset.
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, clocked on clk_i, off during reset.
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SEM_ASSERT_IMPL(lbl, ante, cons, msg)
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/sem_pkg.sv =====
// Shared widths and constants of the Sobel edge magnitude block.
package sem_pkg;

  localparam int PIX_W      = 12;  // input pixel, 4 fraction bits
  localparam int RES_W      = 13;  // edge magnitude / 4
  localparam int IMG_W_W    = 11;  // image_width register
  localparam int IMG_H_W    = 12;  // image_height register
  localparam int CFG_DATA_W = 12;  // widest register
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

  // Gradient datapath: |sx|,|sy| <= 4*4095, sum of squares < 2^30.
  localparam int GRAD_W = 14;
  localparam int SQ_W   = 2 * GRAD_W;
  localparam int SUM_W  = 30;
  localparam int ROOT_W = 31;
  localparam logic [ROOT_W-1:0] SQRT_BIT_INIT = 31'd1 << 28;

  localparam logic [RES_W-1:0] MAX_EDGE = 13'd5792;

endpackage

// ===== sv/sem_pix_if.sv =====
// Pixel input channel: valid/ready handshake plus one gray pixel.
interface sem_pix_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

// ===== sv/sem_res_if.sv =====
// Result output channel: valid/ready handshake plus edge magnitude and marks.
interface sem_res_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] edge_res;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output edge_res, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input edge_res, input row_end, input frame_end,
                  output ready);
endinterface

// ===== sv/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sobel_edge_magnitude.sv =====
// Sobel 3x3 gradient magnitude over a raster pixel stream, top level.
//
// One gray pixel (12 bits, 4 fraction bits) enters per transaction in raster
// order. Two line RAMs keep the two rows above the current one and six
// registers keep the two older window columns. For every interior pixel the
// block returns floor(sqrt(sx^2 + sy^2) / 4) with row_end and frame_end marks;
// border pixels give no result, so a frame yields (height-2) x (width-2)
// results. A border pixel goes through accept and line RAM read and write
// back; an interior pixel adds square, sum and then the bit-serial square
// root, one result bit per cycle, whose last step waits while the result
// register is full. The square root unit sets the pixel rate. The output
// register lets the next pixel be taken while a result waits. Register writes
// (index 0 image_width, index 1 image_height) take effect at once and restart
// the frame; width is clamped to [3, MAX_WIDTH], height to at least 3. The line
// RAMs need no clearing: a result reads only entries written in the same frame.
`include "sobel_edge_magnitude_macros.svh"

module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sem_pix_if.sink                        pix_i,
  sem_res_if.source                      res_o
);
  import sem_pkg::*;

  // Column address width and a width wide enough for the effective width.
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (AW + 1 > IMG_W_W) ? AW + 1 : IMG_W_W;
  localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MIN_W = EW'(3);
  localparam logic [IMG_H_W-1:0] MIN_H = IMG_H_W'(3);

  typedef enum logic [2:0] {
    S_IDLE,    // waiting for a pixel
    S_READ,    // line RAM data back: window, gradients, write back
    S_SQUARE,  // squares of |sx|, |sy|
    S_SUM,     // sum of squares, arm the root unit
    S_SQRT     // one root bit per cycle; last bit waits for a free result register
  } state_e;

  state_e            state_q;
  logic [IMG_W_W-1:0] img_w_q;
  logic [IMG_H_W-1:0] img_h_q;
  logic [AW-1:0]      col_q;
  logic [IMG_H_W-1:0] row_q;
  logic [PIX_W-1:0]   win_q [6];
  logic               row_end_q, frame_end_q;

  // Result register
  logic               res_valid_q;
  logic [RES_W-1:0]   res_edge_q;
  logic               res_row_end_q, res_frame_end_q;

  // Datapath registers (no reset needed)
  logic [PIX_W-1:0]   bot_q;
  logic [GRAD_W-1:0]  ax_q, ay_q;
  logic [SQ_W-1:0]    sqx_q, sqy_q;
  logic [SUM_W-1:0]   n_q;
  logic [ROOT_W-1:0]  root_q, bit_q;

  logic               pix_acc;
  logic               res_free;
  logic [EW-1:0]      eff_w, w_ext, col_ext;
  logic [IMG_H_W-1:0] eff_h;
  logic [PIX_W-1:0]   top, mid;
  logic [GRAD_W-1:0]  gx_pos, gx_neg, gy_pos, gy_neg, ax_d, ay_d;
  logic [SQ_W-1:0]    sqx_d, sqy_d;
  logic [ROOT_W-1:0]  trial, root_d;
  logic [SUM_W-1:0]   n_d;
  logic               take;
  logic               interior, last_col, last_row;

  assign pix_i.ready = (state_q == S_IDLE);
  assign pix_acc     = pix_i.valid && pix_i.ready;
  assign res_free    = !res_valid_q || res_o.ready;

  // Effective frame size
  always_comb begin
    w_ext = EW'(img_w_q);
    if (w_ext < MIN_W) begin
      eff_w = MIN_W;
    end else if (w_ext > MAX_W) begin
      eff_w = MAX_W;
    end else begin
      eff_w = w_ext;
    end
    eff_h = (img_h_q < MIN_H) ? MIN_H : img_h_q;
  end

  assign col_ext  = EW'(col_q);
  assign last_col = (col_ext == eff_w - EW'(1));
  assign last_row = (row_q == eff_h - IMG_H_W'(1));
  assign interior = (row_q >= IMG_H_W'(2)) && (col_ext >= EW'(2));

  // Line stores: older row feeds the window top, newer row the middle.
  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older_line (
    .clk_i   (clk_i),
    .we_i    (state_q == S_READ),
    .waddr_i (col_q),
    .wdata_i (mid),
    .re_i    (pix_acc),
    .raddr_i (col_q),
    .rdata_o (top)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer_line (
    .clk_i   (clk_i),
    .we_i    (state_q == S_READ),
    .waddr_i (col_q),
    .wdata_i (bot_q),
    .re_i    (pix_acc),
    .raddr_i (col_q),
    .rdata_o (mid)
  );

  // Sobel sums split into positive and negative taps; abs by ordered subtract.
  // Window: win 0..2 = left column (t, m, b), win 3..5 = center column.
  always_comb begin
    gx_pos = GRAD_W'(top) + GRAD_W'({mid, 1'b0}) + GRAD_W'(bot_q);
    gx_neg = GRAD_W'(win_q[0]) + GRAD_W'({win_q[1], 1'b0}) + GRAD_W'(win_q[2]);
    gy_pos = GRAD_W'(win_q[2]) + GRAD_W'({win_q[5], 1'b0}) + GRAD_W'(bot_q);
    gy_neg = GRAD_W'(win_q[0]) + GRAD_W'({win_q[3], 1'b0}) + GRAD_W'(top);
    ax_d   = (gx_pos >= gx_neg) ? gx_pos - gx_neg : gx_neg - gx_pos;
    ay_d   = (gy_pos >= gy_neg) ? gy_pos - gy_neg : gy_neg - gy_pos;
  end

  assign sqx_d = ax_q * ax_q;
  assign sqy_d = ay_q * ay_q;

  // One step of the digit-by-digit integer square root.
  always_comb begin
    trial  = root_q + bit_q;
    take   = ROOT_W'(n_q) >= trial;
    root_d = take ? (root_q >> 1) + bit_q : root_q >> 1;
    n_d    = take ? n_q - trial[SUM_W-1:0] : n_q;
  end

  // Control, window, counters and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      img_w_q         <= IMAGE_WIDTH_RST;
      img_h_q         <= IMAGE_HEIGHT_RST;
      col_q           <= '0;
      row_q           <= '0;
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
      row_end_q       <= 1'b0;
      frame_end_q     <= 1'b0;
      res_valid_q     <= 1'b0;
      res_edge_q      <= '0;
      res_row_end_q   <= 1'b0;
      res_frame_end_q <= 1'b0;
    end else begin
      if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (pix_acc) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          win_q[0]    <= win_q[3];
          win_q[1]    <= win_q[4];
          win_q[2]    <= win_q[5];
          win_q[3]    <= top;
          win_q[4]    <= mid;
          win_q[5]    <= bot_q;
          row_end_q   <= last_col;
          frame_end_q <= last_col && last_row;
          if (last_col) begin
            col_q <= '0;
            row_q <= last_row ? '0 : row_q + IMG_H_W'(1);
          end else begin
            col_q <= col_q + AW'(1);
          end
          state_q <= interior ? S_SQUARE : S_IDLE;
        end
        S_SQUARE: state_q <= S_SUM;
        S_SUM:    state_q <= S_SQRT;
        S_SQRT: begin
          // last root step writes straight into the result register
          if (bit_q[0] && res_free) begin
            res_valid_q     <= 1'b1;
            res_edge_q      <= root_d[RES_W+1:2];
            res_row_end_q   <= row_end_q;
            res_frame_end_q <= frame_end_q;
            state_q         <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // register write restarts the frame
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i[IMG_H_W-1:0];
          default:          ;
        endcase
        col_q <= '0;
        row_q <= '0;
      end
    end
  end

  // Arithmetic pipeline
  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      bot_q <= pix_i.pixel;
    end
    unique case (state_q)
      S_READ: begin
        ax_q <= ax_d;
        ay_q <= ay_d;
      end
      S_SQUARE: begin
        sqx_q <= sqx_d;
        sqy_q <= sqy_d;
      end
      S_SUM: begin
        n_q    <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
        root_q <= '0;
        bit_q  <= SQRT_BIT_INIT;
      end
      S_SQRT: begin
        if (!bit_q[0]) begin
          n_q    <= n_d;
          root_q <= root_d;
          bit_q  <= bit_q >> 2;
        end
      end
      default: ;
    endcase
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.edge_res  = res_edge_q;
  assign res_o.row_end   = res_row_end_q;
  assign res_o.frame_end = res_frame_end_q;

  `SEM_ASSERT_NEXT(a_accept_reads, pix_acc, state_q == S_READ, "pixel accepted without RAM read")
  `SEM_ASSERT_IMPL(a_col_range, 1'b1, col_ext < eff_w, "column counter beyond width")
  `SEM_ASSERT_IMPL(a_root_bit, state_q == S_SQRT, $onehot(bit_q), "root step bit lost")
  `SEM_ASSERT_IMPL(a_frame_row, res_o.valid && res_o.frame_end, res_o.row_end, "frame end off row end")
  `SEM_ASSERT_IMPL(a_edge_max, res_o.valid, res_o.edge_res <= MAX_EDGE, "edge magnitude too large")

endmodule
